@@ design/sirt_pkg.sv @@
// Package for the segment interpolator: widths, command and result codes,
// point timing function. No dependencies.
package sirt_pkg;
  localparam int AXES = 6;
  localparam int VAL_W = 32;
  localparam int TICK_W = 16;
  localparam int DIFF_W = 33;
  localparam int RAMP_TICKS = 12;
  localparam int MIN_POINTS = 6;

  localparam logic [1:0] CMD_LOAD  = 2'd0;
  localparam logic [1:0] CMD_START = 2'd1;
  localparam logic [1:0] CMD_NEXT  = 2'd2;
  localparam logic [1:0] CMD_FORCE = 2'd3;

  localparam logic [1:0] KIND_POINT = 2'd0;
  localparam logic [1:0] KIND_IDLE  = 2'd1;
  localparam logic [1:0] KIND_FORCE = 2'd2;

  localparam logic CFG_FORCE_LIMIT = 1'b0;
  localparam logic CFG_SERVO_STEPS = 1'b1;

  typedef logic signed [VAL_W-1:0] val_t;
  typedef val_t [AXES-1:0] axes_t;

  typedef struct packed {
    logic [1:0]        command;
    logic [TICK_W-1:0] duration_ticks;
    axes_t             value;
  } in_word_t;

  typedef struct packed {
    logic [1:0]  kind;
    logic [2:0]  point_ticks;
    logic [9:0]  point_servo_steps;
    axes_t       axis_out;
    logic        last_point;
  } out_word_t;

  function automatic logic [2:0] ticks_for(input logic [TICK_W-1:0] k,
                                           input logic [TICK_W-1:0] n);
    logic [TICK_W-1:0] r;
    r = n - k;
    if (k == 0 || r == 1) return 3'd4;
    if (k == 1 || r == 2) return 3'd3;
    if (k == 2 || r == 3) return 3'd2;
    return 3'd1;
  endfunction
endpackage

@@ design/sirt_if.sv @@
// Valid/ready channel carrying one word of type T.
// The payload type T is a parameter; the interface imports no package.
interface sirt_if #(parameter type T = logic);
  logic valid;
  logic ready;
  T     data;
  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

@@ design/sirt_front.sv @@
// Front end: takes input words, handles load and force check at once,
// queues start and next for the back end. Depends on sirt_pkg.
module sirt_front (
  input  logic                     clk,
  input  logic                     rst_n,
  input  logic                     in_valid,
  output logic                     in_ready,
  input  sirt_pkg::in_word_t       in_data,
  input  logic [14:0]              force_limit,
  output logic                     fq_valid,
  input  logic                     fq_ready,
  output sirt_pkg::in_word_t       fq_data,
  output logic                     fr_valid,
  input  logic                     fr_ready
);
  import sirt_pkg::*;
  // two-entry queue towards the back end
  in_word_t q_r [2];
  logic [1:0] cnt_r, cnt_nxt;
  logic rd_r, rd_nxt, wr_r, wr_nxt;
  logic fr_pend_r, fr_pend_nxt;
  logic danger;
  logic push, pop, acc;

  always_comb begin
    logic [31:0] mag;
    danger = 1'b0;
    for (int i = 0; i < AXES; i++) begin
      mag = in_data.value[i][31] ? 32'(-in_data.value[i]) : in_data.value[i];
      if ({1'b0, mag} > {2'b0, force_limit, 16'd0}) danger = 1'b1;
    end
  end

  // load and force check wait for the queue to drain so they order after
  // earlier starts and nexts
  always_comb begin
    unique case (in_data.command)
      CMD_LOAD:  in_ready = (cnt_r == 2'd0);
      CMD_FORCE: in_ready = (cnt_r == 2'd0) && !fr_pend_r;
      default:   in_ready = (cnt_r != 2'd2);
    endcase
  end

  assign acc  = in_valid && in_ready;
  assign push = acc && (in_data.command == CMD_START || in_data.command == CMD_NEXT);
  assign pop  = fq_valid && fq_ready;
  assign fq_valid = (cnt_r != 2'd0);
  assign fq_data  = q_r[rd_r];
  assign fr_valid = fr_pend_r;

  always_comb begin
    cnt_nxt = cnt_r + {1'b0, push} - {1'b0, pop};
    rd_nxt  = pop ? ~rd_r : rd_r;
    wr_nxt  = push ? ~wr_r : wr_r;
    fr_pend_nxt = fr_pend_r;
    if (fr_valid && fr_ready) fr_pend_nxt = 1'b0;
    if (acc && in_data.command == CMD_FORCE && danger) fr_pend_nxt = 1'b1;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r <= '0; rd_r <= 1'b0; wr_r <= 1'b0; fr_pend_r <= 1'b0;
    end else begin
      cnt_r <= cnt_nxt; rd_r <= rd_nxt; wr_r <= wr_nxt; fr_pend_r <= fr_pend_nxt;
    end
    if (push) q_r[wr_r] <= in_data;
  end

`ifndef SYNTHESIS
  a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
    !(cnt_r == 2'd2 && push)) else $error("queue overflow");
  a_no_underflow: assert property (@(posedge clk) disable iff (!rst_n)
    !(cnt_r == 2'd0 && pop)) else $error("queue underflow");
  a_force_flag: assert property (@(posedge clk) disable iff (!rst_n)
    acc && in_data.command == CMD_FORCE && danger |=> fr_pend_r)
    else $error("force flag lost");
`endif
endmodule

@@ design/sirt_back.sv @@
// Back end: executes start/next, serial divider for the deltas, position
// accumulators, and the load and force results. Depends on sirt_pkg.
module sirt_back (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 fq_valid,
  output logic                 fq_ready,
  input  sirt_pkg::in_word_t   fq_data,
  input  logic                 ld_en,
  input  sirt_pkg::axes_t      ld_value,
  input  logic                 fr_valid,
  output logic                 fr_ready,
  input  logic [7:0]           servo_steps,
  output logic                 o_valid,
  input  logic                 o_ready,
  output sirt_pkg::out_word_t  o_data
);
  import sirt_pkg::*;
  localparam logic [1:0] ST_IDLE = 2'd0;
  localparam logic [1:0] ST_DIV  = 2'd1;
  localparam logic [1:0] ST_EMIT = 2'd2;

  logic [1:0] st_r;
  axes_t pos_r, delta_r;
  logic [TICK_W-1:0] idx_r, tot_r;
  logic active_r;
  logic ov_r;
  out_word_t od_r;
  // divider: restoring, one quotient bit per cycle, one axis at a time
  logic [2:0] ax_r;
  logic [5:0] bit_r;
  logic [DIFF_W-1:0] num_r, quo_r;
  logic [DIFF_W:0] rem_r;
  logic neg_r;
  logic [TICK_W-1:0] n_val;
  logic [TICK_W:0] tk;
  logic [DIFF_W-1:0] diff_mag;
  logic signed [DIFF_W-1:0] diff_s;
  logic [DIFF_W:0] trial;

  assign tk = {1'b0, fq_data.duration_ticks} - (TICK_W+1)'(RAMP_TICKS);
  assign n_val = (tk[TICK_W] || tk[TICK_W-1:0] < TICK_W'(MIN_POINTS)) ?
                 TICK_W'(MIN_POINTS) : tk[TICK_W-1:0];
  assign diff_s = DIFF_W'(fq_data.value[ax_r]) - DIFF_W'(pos_r[ax_r]);
  assign diff_mag = diff_s[DIFF_W-1] ? DIFF_W'(-diff_s) : diff_s;
  assign trial = {rem_r[DIFF_W-1:0], num_r[DIFF_W-1]} - {{(DIFF_W-TICK_W+1){1'b0}}, tot_r};

  assign fq_ready = 1'b0 | (st_r == ST_EMIT && !ov_r);
  assign fr_ready = (st_r == ST_IDLE) && !ov_r;
  assign o_valid = ov_r;
  assign o_data = od_r;

  always_ff @(posedge clk) begin
    out_word_t w;
    logic [2:0] t;
    if (!rst_n) begin
      st_r <= ST_IDLE; ov_r <= 1'b0; active_r <= 1'b0;
      idx_r <= '0; tot_r <= '0; pos_r <= '0; delta_r <= '0;
      ax_r <= '0; bit_r <= '0;
    end else begin
      if (ov_r && o_ready) ov_r <= 1'b0;
      if (ld_en) pos_r <= ld_value;
      w = '0;
      unique case (st_r)
        ST_IDLE: begin
          if (!ov_r && fr_valid) begin
            w.kind = KIND_FORCE; od_r <= w; ov_r <= 1'b1;
          end else if (!ov_r && fq_valid) begin
            if (fq_data.command == CMD_START) begin
              tot_r <= n_val; idx_r <= '0; active_r <= 1'b1;
              ax_r <= '0; bit_r <= '0; st_r <= ST_DIV;
            end else st_r <= ST_EMIT;
          end
        end
        ST_DIV: begin
          if (bit_r == 6'd0) begin
            num_r <= diff_mag; neg_r <= diff_s[DIFF_W-1];
            rem_r <= '0; quo_r <= '0; bit_r <= 6'd1;
          end else begin
            num_r <= num_r << 1;
            if (!trial[DIFF_W]) begin
              rem_r <= trial; quo_r <= {quo_r[DIFF_W-2:0], 1'b1};
            end else begin
              rem_r <= {rem_r[DIFF_W-1:0], num_r[DIFF_W-1]};
              quo_r <= {quo_r[DIFF_W-2:0], 1'b0};
            end
            if (bit_r == 6'(DIFF_W)) begin
              bit_r <= '0;
              if (ax_r == 3'(AXES-1)) st_r <= ST_EMIT;
              else ax_r <= ax_r + 3'd1;
            end else bit_r <= bit_r + 6'd1;
          end
        end
        ST_EMIT: begin
          if (!ov_r) begin
            if (fq_data.command == CMD_START || (active_r && idx_r < tot_r)) begin
              t = ticks_for(idx_r, tot_r);
              w.kind = KIND_POINT;
              w.point_ticks = t;
              w.point_servo_steps = 10'({8'd0, servo_steps} * {13'd0, t});
              for (int i = 0; i < AXES; i++) begin
                w.axis_out[i] = pos_r[i] + delta_r[i];
                pos_r[i] <= pos_r[i] + delta_r[i];
              end
              w.last_point = (idx_r + 16'd1 == tot_r);
              idx_r <= idx_r + 16'd1;
            end else begin
              w.kind = KIND_IDLE; active_r <= 1'b0;
            end
            od_r <= w; ov_r <= 1'b1; st_r <= ST_IDLE;
          end
        end
        default: st_r <= ST_IDLE;
      endcase
      // store the finished quotient of the last bit step
      if (st_r == ST_DIV && bit_r == 6'(DIFF_W)) begin
        delta_r[ax_r] <= VAL_W'(neg_r ? -({quo_r[DIFF_W-2:0], !trial[DIFF_W]})
                                      : {quo_r[DIFF_W-2:0], !trial[DIFF_W]});
      end
    end
  end

`ifndef SYNTHESIS
  a_div_len: assert property (@(posedge clk) disable iff (!rst_n)
    st_r == ST_DIV |-> bit_r <= 6'(DIFF_W)) else $error("divider overrun");
  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    o_valid && !o_ready |=> o_valid && $stable(o_data)) else $error("result dropped");
  a_start_active: assert property (@(posedge clk) disable iff (!rst_n)
    st_r == ST_DIV |-> active_r) else $error("divide without segment");
`endif
endmodule

@@ design/segment_interpolator_ramped_timing_unit.sv @@
// Top level of the six-axis segment interpolator: config registers,
// front end, back end. Depends on sirt_pkg, sirt_if, sirt_front, sirt_back.
//  channel | dir | words
//  in_     | in  | command, duration_ticks, value_0..5
//  out_    | out | kind, ticks, servo steps, axis_out_0..5, last_point
//  cfg_    | in  | force_limit (0), servo_steps_per_tick (1)
// Next emits one word; Start runs the divider for each of the 6 axes in turn, then emits one.
// Load and force check wait for queued moves to finish.
// Reset is synchronous; registers return to 100 and 5. The output register
// holds a word while out_ready is low; the front queue holds two moves.
module segment_interpolator_ramped_timing_unit (
  input  logic        clk,
  input  logic        rst_n,
  sirt_if.sink        in_ch,
  sirt_if.source      out_ch,
  input  logic        cfg_we,
  input  logic        cfg_index,
  input  logic [14:0] cfg_data
);
  import sirt_pkg::*;
  logic [14:0] lim_r;
  logic [7:0] sps_r;
  logic fq_valid, fq_ready, fr_valid, fr_ready, ld_en;
  in_word_t fq_data;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      lim_r <= 15'd100; sps_r <= 8'd5;
    end else if (cfg_we) begin
      unique case (cfg_index)
        CFG_FORCE_LIMIT: lim_r <= cfg_data;
        CFG_SERVO_STEPS: sps_r <= cfg_data[7:0];
        default: ;
      endcase
    end
  end

  assign ld_en = in_ch.valid && in_ch.ready && in_ch.data.command == CMD_LOAD;

  sirt_front u_front (
    .clk, .rst_n,
    .in_valid(in_ch.valid), .in_ready(in_ch.ready), .in_data(in_ch.data),
    .force_limit(lim_r),
    .fq_valid, .fq_ready, .fq_data, .fr_valid, .fr_ready
  );

  sirt_back u_back (
    .clk, .rst_n,
    .fq_valid, .fq_ready, .fq_data,
    .ld_en, .ld_value(in_ch.data.value),
    .fr_valid, .fr_ready, .servo_steps(sps_r),
    .o_valid(out_ch.valid), .o_ready(out_ch.ready), .o_data(out_ch.data)
  );
endmodule

@@ tb/sv/tb.sv @@
`timescale 1ns / 1ps
// Self-checking testbench for segment_interpolator_ramped_timing_unit.
// Needs sirt_pkg, sirt_if and the design; predicts every output word in a class.
module tb;
  import sirt_pkg::*;

  localparam int SETTLE_CYCLES = 300;
  localparam int WATCHDOG_LIMIT = 20000;
  localparam int HOLD_CYCLES = 400;

  class motion_scoreboard;
    logic [31:0] pos_acc[AXES];
    logic [31:0] step_delta[AXES];
    logic [15:0] pt_index, pt_total;
    bit          seg_active;
    logic [14:0] force_lim;
    logic [7:0]  steps_per_tick;
    out_word_t   awaited[$];
    int          mismatches;

    function new();
      foreach (pos_acc[i]) begin
        pos_acc[i] = '0;
        step_delta[i] = '0;
      end
      pt_index = '0;
      pt_total = '0;
      seg_active = 0;
      force_lim = 15'd100;
      steps_per_tick = 8'd5;
      mismatches = 0;
    endfunction

    function void set_reg(logic idx, logic [14:0] data);
      if (idx == CFG_FORCE_LIMIT) force_lim = data;
      else steps_per_tick = data[7:0];
    endfunction

    function void add_awaited(out_word_t o);
      awaited.insert(awaited.size(), o);
    endfunction

    function out_word_t next_point();
      out_word_t o;
      int k, n, t;
      k = pt_index;
      n = pt_total;
      if (k == 0 || k + 1 == n) t = 4;
      else if (k == 1 || k + 2 == n) t = 3;
      else if (k == 2 || k + 3 == n) t = 2;
      else t = 1;
      o = '0;
      o.kind = KIND_POINT;
      for (int i = 0; i < AXES; i++) begin
        pos_acc[i] = pos_acc[i] + step_delta[i];
        o.axis_out[i] = pos_acc[i];
      end
      o.point_ticks = t[2:0];
      o.point_servo_steps = 10'(t * int'(steps_per_tick));
      o.last_point = (k + 1 == n);
      pt_index = pt_index + 16'd1;
      return o;
    endfunction

    function void note_input(in_word_t w);
      out_word_t o;
      longint n, diff, lim, f;
      bit hot;
      case (w.command)
        CMD_LOAD: begin
          for (int i = 0; i < AXES; i++) pos_acc[i] = w.value[i];
        end
        CMD_START: begin
          n = longint'(w.duration_ticks) - RAMP_TICKS;
          if (n < MIN_POINTS) n = MIN_POINTS;
          for (int i = 0; i < AXES; i++) begin
            diff = longint'(w.value[i]) - longint'($signed(pos_acc[i]));
            step_delta[i] = 32'(diff / n);
          end
          pt_total = 16'(n);
          pt_index = '0;
          seg_active = 1;
          add_awaited(next_point());
        end
        CMD_NEXT: begin
          if (seg_active && pt_index < pt_total) begin
            add_awaited(next_point());
          end else begin
            seg_active = 0;
            o = '0;
            o.kind = KIND_IDLE;
            add_awaited(o);
          end
        end
        default: begin
          lim = longint'(force_lim) * 65536;
          hot = 0;
          for (int i = 0; i < AXES; i++) begin
            f = longint'(w.value[i]);
            if (f < 0) f = -f;
            if (f > lim) hot = 1;
          end
          if (hot) begin
            o = '0;
            o.kind = KIND_FORCE;
            add_awaited(o);
          end
        end
      endcase
    endfunction

    function void check_result(out_word_t got);
      out_word_t exp_w;
      bit bad;
      if (awaited.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("tb: unexpected word %h", got);
        return;
      end
      exp_w = awaited.pop_front();
      bad = (got.kind !== exp_w.kind) || (got.point_ticks !== exp_w.point_ticks) ||
            (got.point_servo_steps !== exp_w.point_servo_steps) ||
            (got.last_point !== exp_w.last_point);
      for (int i = 0; i < AXES; i++)
        if (got.axis_out[i] !== exp_w.axis_out[i]) bad = 1;
      if (bad) begin
        mismatches++;
        if (mismatches <= 10)
          $display("tb: mismatch expected %h actual %h", exp_w, got);
      end
    endfunction
  endclass

  logic clk = 0;
  logic rst_n = 0;
  logic cfg_we = 0;
  logic cfg_index = 0;
  logic [14:0] cfg_data = '0;

  sirt_if #(in_word_t)  in_ch ();
  sirt_if #(out_word_t) out_ch ();

  segment_interpolator_ramped_timing_unit u_top (
    .clk(clk), .rst_n(rst_n), .in_ch(in_ch.sink), .out_ch(out_ch.source),
    .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data)
  );

  always #1 clk = ~clk;

  motion_scoreboard sb = new();
  int idle_pct = 15;
  int hold_left = 0;
  bit hold_req = 0;
  int quiet_cycles = 0;

  initial begin
    in_ch.valid = 0;
    in_ch.data = '0;
    out_ch.ready = 0;
  end

  // receiver side: random stalls plus one long hold-off when asked
  always @(negedge clk) begin
    if (hold_req) begin
      hold_req = 0;
      hold_left = HOLD_CYCLES;
    end
    if (hold_left > 0) begin
      hold_left--;
      out_ch.ready = 0;
    end else begin
      out_ch.ready = rst_n && ($urandom_range(99) >= idle_pct);
    end
  end

  always @(posedge clk) begin
    if (rst_n && out_ch.valid && out_ch.ready) sb.check_result(out_ch.data);
  end

  always @(posedge clk) begin
    if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready)) quiet_cycles = 0;
    else quiet_cycles++;
    if (quiet_cycles >= WATCHDOG_LIMIT) begin
      $display("tb: done, errors");
      $finish;
    end
  end

  task automatic send_word(in_word_t w);
    while ($urandom_range(99) < idle_pct) begin
      @(negedge clk);
      in_ch.valid = 0;
    end
    @(negedge clk);
    in_ch.valid = 1;
    in_ch.data = w;
    do @(posedge clk); while (!in_ch.ready);
    sb.note_input(w);
  endtask

  task automatic send_cmd(logic [1:0] cmd, logic [15:0] ticks, axes_t vals);
    in_word_t w;
    w.command = cmd;
    w.duration_ticks = ticks;
    w.value = vals;
    send_word(w);
  endtask

  function automatic axes_t rand_axes();
    axes_t a;
    for (int i = 0; i < AXES; i++) a[i] = $urandom;
    return a;
  endfunction

  function automatic axes_t fill_axes(val_t v);
    axes_t a;
    for (int i = 0; i < AXES; i++) a[i] = v;
    return a;
  endfunction

  function automatic axes_t near_axes();
    axes_t a;
    for (int i = 0; i < AXES; i++) a[i] = $signed(32'($urandom_range(2000000))) - 1000000;
    return a;
  endfunction

  // drain, let any no-result word finish, then write a register
  task automatic write_reg(logic idx, logic [14:0] data);
    @(negedge clk);
    in_ch.valid = 0;
    while (sb.awaited.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
    @(negedge clk);
    cfg_we = 1;
    cfg_index = idx;
    cfg_data = data;
    @(negedge clk);
    cfg_we = 0;
    sb.set_reg(idx, data);
  endtask

  task automatic random_phase(int words, bit with_hold);
    int sent, n;
    logic [15:0] dur;
    sent = 0;
    while (sent < words) begin
      if ($urandom_range(99) < 80) begin
        // well-formed segment: load, start, then nexts; short ones run to or a little past the end
        send_cmd(CMD_LOAD, 0, ($urandom_range(3) == 0) ? rand_axes() : near_axes());
        dur = ($urandom_range(19) == 0) ? 16'($urandom) : 16'($urandom_range(30));
        send_cmd(CMD_START, dur, ($urandom_range(3) == 0) ? rand_axes() : near_axes());
        n = int'(dur) - RAMP_TICKS;
        if (n < MIN_POINTS) n = MIN_POINTS;
        if (n > 40) n = $urandom_range(40, 10);
        n = n - 1 + $urandom_range(2);
        sent += 2 + n;
        for (int k = 0; k < n; k++) begin
          if (with_hold && k == 2 && sent > words / 2) begin
            with_hold = 0;
            hold_req = 1;
          end
          if ($urandom_range(9) == 0) begin
            send_cmd(CMD_FORCE, 16'($urandom), near_axes());
            sent++;
          end
          send_cmd(CMD_NEXT, 16'($urandom), rand_axes());
        end
      end else begin
        send_cmd(2'($urandom_range(3)), 16'($urandom),
                 ($urandom_range(1) == 0) ? rand_axes() : near_axes());
        sent++;
      end
    end
  endtask

  initial begin
    repeat (12) @(posedge clk);
    @(negedge clk);
    rst_n = 1;

    // directed: idle next, force edges, loads at extremes, short and long segments
    send_cmd(CMD_NEXT, 0, '0);
    send_cmd(CMD_FORCE, 0, fill_axes(32'sd6553600));
    send_cmd(CMD_FORCE, 0, fill_axes(32'sd6553601));
    send_cmd(CMD_FORCE, 0, fill_axes(-32'sd6553601));
    send_cmd(CMD_FORCE, 16'hffff, fill_axes(32'sh80000000));
    send_cmd(CMD_LOAD, 16'hffff, fill_axes(32'sh80000000));
    send_cmd(CMD_START, 0, fill_axes(32'sh7fffffff));
    for (int k = 0; k < 7; k++) send_cmd(CMD_NEXT, 0, '1);
    send_cmd(CMD_LOAD, 0, fill_axes(32'sh7fffffff));
    send_cmd(CMD_START, 16'd19, fill_axes(32'sh80000000));
    send_cmd(CMD_NEXT, 0, '0);
    send_cmd(CMD_START, 16'hffff, rand_axes());
    send_cmd(CMD_NEXT, 0, '0);
    send_cmd(CMD_START, 16'd18, fill_axes(32'sd0));
    for (int k = 0; k < 6; k++) send_cmd(CMD_NEXT, 0, '0);

    write_reg(CFG_FORCE_LIMIT, 15'd0);
    write_reg(CFG_SERVO_STEPS, 15'd255);
    send_cmd(CMD_FORCE, 0, fill_axes(32'sd0));
    send_cmd(CMD_FORCE, 0, fill_axes(32'sd1));
    random_phase(300, 1);

    write_reg(CFG_FORCE_LIMIT, 15'h7fff);
    write_reg(CFG_SERVO_STEPS, 15'd1);
    send_cmd(CMD_FORCE, 0, fill_axes(32'sh80000000));
    send_cmd(CMD_FORCE, 0, fill_axes(32'sh7fffffff));
    idle_pct = 0;
    random_phase(300, 0);
    idle_pct = 15;

    write_reg(CFG_SERVO_STEPS, 15'd0);
    write_reg(CFG_FORCE_LIMIT, 15'($urandom_range(200)));
    random_phase(150, 0);

    write_reg(CFG_SERVO_STEPS, 15'($urandom_range(255, 1)));
    write_reg(CFG_FORCE_LIMIT, 15'($urandom));
    random_phase(450, 0);

    @(negedge clk);
    in_ch.valid = 0;
    while (sb.awaited.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
    if (sb.mismatches == 0 && sb.awaited.size() == 0) begin
      $display("tb: done, clean");
    end else begin
      $display("tb: done, errors");
    end
    $finish;
  end
endmodule
